[hw/rtl/obs_pkg.sv]
// Shared types, codes and constants for the obstacle bypass sequencer.
// Used by obs_cfg, obs_core and the top level; depends on nothing.
package obs_pkg;

    // Register file geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_OBSTACLE = 3'd0;
    localparam logic [2:0] REG_BYPASS   = 3'd1;
    localparam logic [2:0] REG_FWD_SPD  = 3'd2;
    localparam logic [2:0] REG_TURN_SPD = 3'd3;
    localparam logic [2:0] REG_ANGLE    = 3'd4;

    // Command codes
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // Angles in tenths of a degree, times in ms
    localparam logic signed [13:0] FULL_TURN  = 14'sd3600;
    localparam logic signed [13:0] HALF_TURN  = 14'sd1800;
    localparam logic signed [13:0] TOLERANCE  = 14'sd50;
    localparam logic [31:0]        HOLD_MS    = 32'd300;
    localparam logic [31:0]        SETTLE_MS  = 32'd500;
    localparam logic [31:0]        TIMEOUT_MS = 32'd5000;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_STOP  = 3'd1,
        PH_CHECK = 3'd2,
        PH_TURN1 = 3'd3,
        PH_FWD   = 3'd4,
        PH_TURN2 = 3'd5,
        PH_DONE  = 3'd6,
        PH_FAIL  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [15:0] obstacle_mm;
        logic [15:0] bypass_mm;
        logic [14:0] drive_speed;
        logic [14:0] spin_speed;
        logic [11:0] turn_angle;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [1:0]  dir_req;
        logic [11:0] heading;
        logic [31:0] odometer_mm;
        logic [15:0] front_mm;
    } item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  direction;
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic        start_ok;
    } res_t;

endpackage

[hw/rtl/obstacle_bypass_sequencer.sv]
// Obstacle bypass sequencer top level: input register, step logic, result register.
// Depends on obs_pkg, obs_cfg and obs_core.
//
// Each request is captured in the input register, the manoeuvre step is worked out
// from that register and the held state in a single pass, and the result is
// registered. The state registers feed straight back into that step, which sets the
// rate at one request per clock while the result register is free or being emptied;
// the input register takes one more request while an earlier result still waits to
// be taken. Configuration writes must be made while no request is in flight.
module obstacle_bypass_sequencer
    import obs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [31:0]        now_ms,
    input  logic [1:0]         dir_req,
    input  logic [11:0]        heading,
    input  logic signed [31:0] odometer_mm,
    input  logic [15:0]        front_mm,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         phase,
    output logic [1:0]         direction,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed,
    output logic               start_ok,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_v_reg;
    res_t  res_reg;
    logic  out_v_reg;
    res_t  result;
    logic  step_en;
    logic  take_in;

    obs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    obs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Advance when the result register is free or being emptied
    assign step_en  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || step_en;
    assign take_in  = in_valid && in_ready;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_ready)
            in_v_reg <= in_valid;
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.cmd         <= cmd;
            item_reg.now_ms      <= now_ms;
            item_reg.dir_req     <= dir_req;
            item_reg.heading     <= heading;
            item_reg.odometer_mm <= odometer_mm;
            item_reg.front_mm    <= front_mm;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (step_en)
            out_v_reg <= 1'b1;
        else if (out_ready)
            out_v_reg <= 1'b0;
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= result;
    end

    assign out_valid   = out_v_reg;
    assign phase       = res_reg.phase;
    assign direction   = res_reg.direction;
    assign left_speed  = res_reg.left_speed;
    assign right_speed = res_reg.right_speed;
    assign start_ok    = res_reg.start_ok;

endmodule

[hw/rtl/obs_cfg.sv]
// Configuration register file of the obstacle bypass sequencer, APB-style port.
// Depends on obs_pkg for the register indexes and the cfg_t bundle.
module obs_cfg
    import obs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [15:0] obstacle_reg;
    logic [15:0] bypass_reg;
    logic [14:0] fwd_spd_reg;
    logic [14:0] turn_spd_reg;
    logic [11:0] angle_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Write on the access phase of a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg <= 16'd250;
            bypass_reg   <= 16'd300;
            fwd_spd_reg  <= 15'd90;
            turn_spd_reg <= 15'd90;
            angle_reg    <= 12'd900;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OBSTACLE: obstacle_reg <= pwdata[15:0];
                REG_BYPASS:   bypass_reg   <= pwdata[15:0];
                REG_FWD_SPD:  fwd_spd_reg  <= pwdata[14:0];
                REG_TURN_SPD: turn_spd_reg <= pwdata[14:0];
                REG_ANGLE:    angle_reg    <= pwdata[11:0];
                default:      ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_OBSTACLE: prdata = {16'd0, obstacle_reg};
            REG_BYPASS:   prdata = {16'd0, bypass_reg};
            REG_FWD_SPD:  prdata = {17'd0, fwd_spd_reg};
            REG_TURN_SPD: prdata = {17'd0, turn_spd_reg};
            REG_ANGLE:    prdata = {20'd0, angle_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.obstacle_mm = obstacle_reg;
    assign cfg.bypass_mm   = bypass_reg;
    assign cfg.drive_speed = fwd_spd_reg;
    assign cfg.spin_speed  = turn_spd_reg;
    assign cfg.turn_angle  = angle_reg;

endmodule

[hw/rtl/obs_core.sv]
// Manoeuvre state machine: holds the bypass state, one request per cycle on step_en.
// Depends on obs_pkg for phase_t, cfg_t, item_t, res_t and the codes.
module obs_core
    import obs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  result
);

    phase_t             phase_reg, phase_next;
    logic [1:0]         dir_reg, dir_next;
    logic [11:0]        start_reg, start_next;
    logic [11:0]        target_reg, target_next;
    logic [31:0]        odo_mark_reg, odo_mark_next;
    logic [31:0]        ptime_reg, ptime_next;
    logic [31:0]        htime_reg, htime_next;
    logic               holding_reg, holding_next;
    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;

    logic               ok;
    logic               enter;
    phase_t             enter_phase;
    logic [31:0]        elapsed;
    logic [31:0]        held;
    logic               settle_done;
    logic               timeout;
    logic               hold_due;
    logic               blocked;
    logic signed [13:0] err_raw;
    logic signed [13:0] err_w;
    logic               in_tol;
    logic               reached;
    logic signed [15:0] spd_turn;
    logic signed [15:0] spd_fwd;
    logic signed [15:0] rot_left;
    logic signed [15:0] rot_right;
    logic [11:0]        cur_wrap;
    logic signed [13:0] turn_sum;
    logic [11:0]        turn_target;
    logic signed [32:0] odo_diff;
    logic               fwd_gone;

    // Wrap an angle sum into [0, 3600)
    function automatic logic [11:0] wrap_full(input logic signed [13:0] a);
        logic signed [13:0] w;
        begin
            if (a < -FULL_TURN)
                w = a + (FULL_TURN <<< 1);
            else if (a < 14'sd0)
                w = a + FULL_TURN;
            else if (a >= (FULL_TURN <<< 1))
                w = a - (FULL_TURN <<< 1);
            else if (a >= FULL_TURN)
                w = a - FULL_TURN;
            else
                w = a;
            wrap_full = w[11:0];
        end
    endfunction

    // Timers
    assign elapsed     = item.now_ms - ptime_reg;
    assign held        = item.now_ms - htime_reg;
    assign settle_done = elapsed >= SETTLE_MS;
    assign timeout     = elapsed >= TIMEOUT_MS;
    assign hold_due    = held >= HOLD_MS;
    assign blocked     = item.front_mm <= cfg.obstacle_mm;

    // Heading error wrapped into [-1800, 1800]
    assign err_raw = $signed({2'b00, target_reg}) - $signed({2'b00, item.heading});
    always_comb
    begin
        if (err_raw > HALF_TURN)
            err_w = err_raw - FULL_TURN;
        else if (err_raw < -HALF_TURN)
            err_w = err_raw + FULL_TURN;
        else
            err_w = err_raw;
    end
    assign in_tol  = (err_w <= TOLERANCE) && (err_w >= -TOLERANCE);
    assign reached = in_tol && holding_reg && hold_due;

    // Rotate-in-place wheel targets
    assign spd_turn = $signed({1'b0, cfg.spin_speed});
    assign spd_fwd  = $signed({1'b0, cfg.drive_speed});
    always_comb
    begin
        if (in_tol)
        begin
            rot_left  = 16'sd0;
            rot_right = 16'sd0;
        end
        else if (err_w > 14'sd0)
        begin
            rot_left  = -spd_turn;
            rot_right = spd_turn;
        end
        else
        begin
            rot_left  = spd_turn;
            rot_right = -spd_turn;
        end
    end

    // Start heading and first turn target
    assign cur_wrap = (item.heading >= FULL_TURN[11:0]) ? item.heading - FULL_TURN[11:0]
                                                        : item.heading;
    assign turn_sum = (dir_reg == DIR_RIGHT)
                    ? $signed({2'b00, start_reg}) - $signed({2'b00, cfg.turn_angle})
                    : $signed({2'b00, start_reg}) + $signed({2'b00, cfg.turn_angle});
    assign turn_target = wrap_full(turn_sum);

    // Forward progress, exact 33-bit difference
    assign odo_diff = $signed({item.odometer_mm[31], item.odometer_mm})
                    - $signed({odo_mark_reg[31], odo_mark_reg});
    assign fwd_gone = odo_diff >= $signed({17'd0, cfg.bypass_mm});

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        start_next    = start_reg;
        target_next   = target_reg;
        odo_mark_next = odo_mark_reg;
        ptime_next    = ptime_reg;
        htime_next    = htime_reg;
        holding_next  = holding_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        ok            = 1'b0;
        enter         = 1'b0;
        enter_phase   = phase_reg;

        case (item.cmd)
            CMD_UPDATE:
            begin
                case (phase_reg)
                    PH_STOP:
                    begin
                        left_next  = 16'sd0;
                        right_next = 16'sd0;
                        if (settle_done)
                        begin
                            enter       = 1'b1;
                            enter_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        left_next  = 16'sd0;
                        right_next = 16'sd0;
                        enter      = 1'b1;
                        if (dir_reg == DIR_NONE)
                            enter_phase = PH_FAIL;
                        else
                        begin
                            target_next = turn_target;
                            enter_phase = PH_TURN1;
                        end
                    end
                    PH_TURN1, PH_TURN2:
                    begin
                        left_next  = rot_left;
                        right_next = rot_right;
                        if (timeout)
                        begin
                            left_next   = 16'sd0;
                            right_next  = 16'sd0;
                            enter       = 1'b1;
                            enter_phase = PH_FAIL;
                        end
                        else
                        begin
                            // Track how long the heading has stayed in tolerance
                            if (in_tol)
                            begin
                                if (!holding_reg)
                                begin
                                    holding_next = 1'b1;
                                    htime_next   = item.now_ms;
                                end
                            end
                            else
                                holding_next = 1'b0;
                            if (reached)
                            begin
                                enter = 1'b1;
                                if (blocked)
                                begin
                                    left_next   = 16'sd0;
                                    right_next  = 16'sd0;
                                    enter_phase = PH_FAIL;
                                end
                                else if (phase_reg == PH_TURN1)
                                begin
                                    odo_mark_next = item.odometer_mm;
                                    left_next     = spd_fwd;
                                    right_next    = spd_fwd;
                                    enter_phase   = PH_FWD;
                                end
                                else
                                begin
                                    left_next   = 16'sd0;
                                    right_next  = 16'sd0;
                                    enter_phase = PH_DONE;
                                end
                            end
                        end
                    end
                    PH_FWD:
                    begin
                        if (blocked)
                        begin
                            left_next   = 16'sd0;
                            right_next  = 16'sd0;
                            enter       = 1'b1;
                            enter_phase = PH_FAIL;
                        end
                        else
                        begin
                            left_next  = spd_fwd;
                            right_next = spd_fwd;
                            if (fwd_gone)
                            begin
                                target_next = start_reg;
                                enter       = 1'b1;
                                enter_phase = PH_TURN2;
                            end
                        end
                    end
                    default:
                    begin
                        left_next  = 16'sd0;
                        right_next = 16'sd0;
                    end
                endcase
            end
            CMD_START:
            begin
                left_next  = 16'sd0;
                right_next = 16'sd0;
                enter      = 1'b1;
                if ((item.dir_req == DIR_LEFT) || (item.dir_req == DIR_RIGHT))
                begin
                    dir_next      = item.dir_req;
                    start_next    = cur_wrap;
                    target_next   = cur_wrap;
                    odo_mark_next = item.odometer_mm;
                    enter_phase   = PH_STOP;
                    ok            = 1'b1;
                end
                else
                    enter_phase = PH_FAIL;
            end
            CMD_RESET:
            begin
                dir_next      = DIR_NONE;
                start_next    = '0;
                target_next   = '0;
                odo_mark_next = '0;
                left_next     = 16'sd0;
                right_next    = 16'sd0;
                enter         = 1'b1;
                enter_phase   = PH_IDLE;
            end
            default: ;
        endcase

        // Entering a phase restarts its timer and drops any hold
        if (enter)
        begin
            phase_next   = enter_phase;
            ptime_next   = item.now_ms;
            htime_next   = '0;
            holding_next = 1'b0;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            dir_reg      <= DIR_NONE;
            start_reg    <= '0;
            target_reg   <= '0;
            odo_mark_reg <= '0;
            ptime_reg    <= '0;
            htime_reg    <= '0;
            holding_reg  <= 1'b0;
            left_reg     <= '0;
            right_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            dir_reg      <= dir_next;
            start_reg    <= start_next;
            target_reg   <= target_next;
            odo_mark_reg <= odo_mark_next;
            ptime_reg    <= ptime_next;
            htime_reg    <= htime_next;
            holding_reg  <= holding_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
        end
    end

    assign result.phase       = phase_next;
    assign result.direction   = dir_next;
    assign result.left_speed  = left_next;
    assign result.right_speed = right_next;
    assign result.start_ok    = ok;

`ifndef SYNTH
    // Wheels stand still outside the turning and driving phases
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_STOP || phase_reg == PH_CHECK ||
         phase_reg == PH_DONE || phase_reg == PH_FAIL)
        |-> (left_reg == 16'sd0 && right_reg == 16'sd0))
        else $error("wheels moving in a resting phase");

    // Both wheels match while driving forward
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FWD) |-> (left_reg == right_reg))
        else $error("unequal wheels while driving forward");

    // Heading hold only runs during a turn
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        holding_reg |-> (phase_reg == PH_TURN1 || phase_reg == PH_TURN2))
        else $error("heading hold outside a turn");

    // A valid start always lands in the stop phase
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.cmd == CMD_START &&
         (item.dir_req == DIR_LEFT || item.dir_req == DIR_RIGHT)) |=> (phase_reg == PH_STOP))
        else $error("start request did not enter stop phase");

    // Phase moves only on an accepted request
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg))
        else $error("phase changed without a request");
`endif

endmodule

[test/obstacle_bypass_sequencer_tb.sv]
// Self-checking testbench for the obstacle bypass sequencer: directed manoeuvres, random
// manoeuvre streams under idling and back-pressure, and register sweeps over the APB port.
// Depends on obs_pkg and the obstacle_bypass_sequencer RTL only.
module obstacle_bypass_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obs_pkg::*;

    // Codes with no name in the package
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] DIR_BAD    = 2'd3;

    localparam cfg_t CFG_RESET = '{16'd250, 16'd300, 15'd90, 15'd90, 12'd900};
    localparam int   STALL_LIMIT = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [31:0]        now_ms;
    logic [1:0]         dir_req;
    logic [11:0]        heading;
    logic signed [31:0] odometer_mm;
    logic [15:0]        front_mm;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         phase;
    logic [1:0]         direction;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               start_ok;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    obstacle_bypass_sequencer dut (.*);

    // Manoeuvre predictor state
    cfg_t               cfg_now;
    phase_t             mv_phase;
    logic [1:0]         mv_dir;
    int                 hdg_start;
    int                 hdg_target;
    logic signed [31:0] odo_ref;
    logic [31:0]        t_entry;
    logic [31:0]        t_hold;
    bit                 hold_on;
    logic signed [15:0] whl_l;
    logic signed [15:0] whl_r;

    res_t expected_moves[$];

    // Stimulus plant and run bookkeeping
    logic [31:0]        p_now;
    logic signed [31:0] p_odo;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;
    int requests_sent;
    int results_checked;
    int reg_writes;
    int mismatches;
    int phase_hits[8];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int wrap_circle(int a);
        int r;
        r = a % int'(FULL_TURN);
        if (r < 0)
            r += int'(FULL_TURN);
        return r;
    endfunction

    function automatic int wrap_signed(int e);
        while (e > int'(HALF_TURN))
            e -= int'(FULL_TURN);
        while (e < -int'(HALF_TURN))
            e += int'(FULL_TURN);
        return e;
    endfunction

    function automatic void drive_wheels(int l, int r);
        whl_l = 16'(l);
        whl_r = 16'(r);
    endfunction

    function automatic void enter_phase(phase_t p, logic [31:0] t);
        mv_phase = p;
        t_entry  = t;
        t_hold   = '0;
        hold_on  = 1'b0;
    endfunction

    function automatic void reset_manoeuvre();
        cfg_now    = CFG_RESET;
        mv_phase   = PH_IDLE;
        mv_dir     = DIR_NONE;
        hdg_start  = 0;
        hdg_target = 0;
        odo_ref    = '0;
        t_entry    = '0;
        t_hold     = '0;
        hold_on    = 1'b0;
        whl_l      = '0;
        whl_r      = '0;
    endfunction

    // Rotate in place towards the target, stopping inside the tolerance band
    function automatic void steer(int cur);
        int s;
        int e;
        s = int'(cfg_now.spin_speed);
        e = wrap_signed(hdg_target - cur);
        if (e <= int'(TOLERANCE) && e >= -int'(TOLERANCE))
            drive_wheels(0, 0);
        else if (e > 0)
            drive_wheels(-s, s);
        else
            drive_wheels(s, -s);
    endfunction

    // True once the heading has stayed inside the band for the hold time
    function automatic bit heading_held(int cur, logic [31:0] t);
        int d;
        logic [31:0] held;
        d = wrap_signed(hdg_target - cur);
        if (d < 0)
            d = -d;
        if (d <= int'(TOLERANCE))
        begin
            held = t - t_hold;
            if (!hold_on)
            begin
                hold_on = 1'b1;
                t_hold  = t;
            end
            else if (held >= HOLD_MS)
                return 1'b1;
        end
        else
            hold_on = 1'b0;
        return 1'b0;
    endfunction

    function automatic void advance(logic [31:0] t, int cur, logic signed [31:0] odo,
                                    logic [15:0] front);
        logic [31:0] elapsed;
        bit          blocked;
        longint      travelled;
        elapsed = t - t_entry;
        blocked = front <= cfg_now.obstacle_mm;
        case (mv_phase)
            PH_STOP:
            begin
                drive_wheels(0, 0);
                if (elapsed >= SETTLE_MS)
                    enter_phase(PH_CHECK, t);
            end
            PH_CHECK:
            begin
                drive_wheels(0, 0);
                if (mv_dir == DIR_NONE)
                    enter_phase(PH_FAIL, t);
                else
                begin
                    if (mv_dir == DIR_RIGHT)
                        hdg_target = wrap_circle(hdg_start - int'(cfg_now.turn_angle));
                    else
                        hdg_target = wrap_circle(hdg_start + int'(cfg_now.turn_angle));
                    enter_phase(PH_TURN1, t);
                end
            end
            PH_TURN1:
            begin
                steer(cur);
                if (elapsed >= TIMEOUT_MS)
                begin
                    drive_wheels(0, 0);
                    enter_phase(PH_FAIL, t);
                end
                else if (heading_held(cur, t))
                begin
                    if (blocked)
                    begin
                        drive_wheels(0, 0);
                        enter_phase(PH_FAIL, t);
                    end
                    else
                    begin
                        odo_ref = odo;
                        drive_wheels(int'(cfg_now.drive_speed), int'(cfg_now.drive_speed));
                        enter_phase(PH_FWD, t);
                    end
                end
            end
            PH_FWD:
            begin
                if (blocked)
                begin
                    drive_wheels(0, 0);
                    enter_phase(PH_FAIL, t);
                end
                else
                begin
                    drive_wheels(int'(cfg_now.drive_speed), int'(cfg_now.drive_speed));
                    // distance is exact, never wrapped to 32 bits
                    travelled = longint'(odo) - longint'(odo_ref);
                    if (travelled >= longint'(cfg_now.bypass_mm))
                    begin
                        hdg_target = wrap_circle(hdg_start);
                        enter_phase(PH_TURN2, t);
                    end
                end
            end
            PH_TURN2:
            begin
                steer(cur);
                if (elapsed >= TIMEOUT_MS)
                begin
                    drive_wheels(0, 0);
                    enter_phase(PH_FAIL, t);
                end
                else if (heading_held(cur, t))
                begin
                    drive_wheels(0, 0);
                    enter_phase(blocked ? PH_FAIL : PH_DONE, t);
                end
            end
            default:
                drive_wheels(0, 0);
        endcase
    endfunction

    function automatic res_t step_manoeuvre(item_t it);
        res_t r;
        bit   ok;
        ok = 1'b0;
        case (it.cmd)
            CMD_UPDATE:
                advance(it.now_ms, int'(it.heading), it.odometer_mm, it.front_mm);
            CMD_START:
            begin
                drive_wheels(0, 0);
                if (it.dir_req == DIR_LEFT || it.dir_req == DIR_RIGHT)
                begin
                    mv_dir     = it.dir_req;
                    hdg_start  = wrap_circle(int'(it.heading));
                    hdg_target = hdg_start;
                    odo_ref    = it.odometer_mm;
                    enter_phase(PH_STOP, it.now_ms);
                    ok = 1'b1;
                end
                else
                    enter_phase(PH_FAIL, it.now_ms);
            end
            CMD_RESET:
            begin
                mv_dir     = DIR_NONE;
                hdg_start  = 0;
                hdg_target = 0;
                odo_ref    = '0;
                drive_wheels(0, 0);
                enter_phase(PH_IDLE, it.now_ms);
            end
            default: ;
        endcase
        r.phase       = mv_phase;
        r.direction   = mv_dir;
        r.left_speed  = whl_l;
        r.right_speed = whl_r;
        r.start_ok    = ok;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one request, hold it until taken, then record its expected result
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= it.cmd;
        now_ms      <= it.now_ms;
        dir_req     <= it.dir_req;
        heading     <= it.heading;
        odometer_mm <= it.odometer_mm;
        front_mm    <= it.front_mm;
        do @(posedge clk); while (!in_ready);
        expected_moves.push_back(step_manoeuvre(it));
        requests_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] c, input logic [31:0] t, input logic [1:0] d,
                            input logic [11:0] h, input logic [31:0] o, input logic [15:0] f);
        item_t it;
        it.cmd         = c;
        it.now_ms      = t;
        it.dir_req     = d;
        it.heading     = h;
        it.odometer_mm = o;
        it.front_mm    = f;
        send_item(it);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write; the caller drops psel after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_OBSTACLE: cfg_now.obstacle_mm = val[15:0];
            REG_BYPASS:   cfg_now.bypass_mm   = val[15:0];
            REG_FWD_SPD:  cfg_now.drive_speed = val[14:0];
            REG_TURN_SPD: cfg_now.spin_speed  = val[14:0];
            REG_ANGLE:    cfg_now.turn_angle  = val[11:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input cfg_t c);
        drain_results();
        write_reg(REG_OBSTACLE, 32'(c.obstacle_mm));
        write_reg(REG_BYPASS,   32'(c.bypass_mm));
        write_reg(REG_FWD_SPD,  32'(c.drive_speed));
        write_reg(REG_TURN_SPD, 32'(c.spin_speed));
        write_reg(REG_ANGLE,    32'(c.turn_angle));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random manoeuvre stream, steered by the predicted phase
    task automatic random_items(input int n);
        item_t it;
        int    roll;
        int    pick;
        int    off;
        int    h;
        repeat (n)
        begin
            roll = $urandom_range(99);
            it.cmd         = CMD_UPDATE;
            it.dir_req     = 2'($urandom);
            it.odometer_mm = p_odo;
            // front range: mostly clear, sometimes blocked
            if ($urandom_range(99) < 4 || cfg_now.obstacle_mm == 16'hFFFF)
                it.front_mm = 16'($urandom_range(cfg_now.obstacle_mm));
            else
                it.front_mm = 16'($urandom_range(65535, cfg_now.obstacle_mm + 1));
            if (roll < 2)
            begin
                // noise: any bit pattern at all
                it = {$urandom, $urandom, $urandom};
            end
            else if (roll < 5 || mv_phase inside {PH_IDLE, PH_DONE, PH_FAIL})
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    it.cmd = CMD_START;
                else if (pick < 90)
                    it.cmd = CMD_RESET;
                else if (pick < 95)
                    it.cmd = CMD_UPDATE;
                else
                    it.cmd = CMD_UNUSED;
                if ($urandom_range(99) < 90)
                    it.dir_req = $urandom_range(1) ? DIR_LEFT : DIR_RIGHT;
                else
                    it.dir_req = $urandom_range(1) ? DIR_NONE : DIR_BAD;
                it.heading = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(3599));
                pick = $urandom_range(9);
                if (pick == 0)
                    p_odo = 32'h7FFF_FFFF - $urandom_range(400);
                else if (pick == 1)
                    p_odo = 32'h8000_0000 + $urandom_range(400);
                else
                    p_odo = $urandom;
                it.odometer_mm = p_odo;
                p_now += $urandom_range(200, 1);
                it.now_ms = p_now;
            end
            else
            begin
                // well-formed update: time moves on, heading mostly near the target
                if (mv_phase == PH_STOP)
                    p_now += $urandom_range(300, 100);
                else if ($urandom_range(99) < 2)
                    p_now += 5000 + $urandom_range(100);
                else
                    p_now += $urandom_range(150, 20);
                it.now_ms = p_now;
                if ($urandom_range(99) < 80)
                begin
                    off = int'($urandom_range(100)) - 50;
                    if ($urandom_range(19) == 0)
                        off = (off < 0) ? off - 30 : off + 30;
                    h = wrap_circle(hdg_target + off);
                    if (h < 496 && $urandom_range(3) == 0)
                        h += 3600;
                    it.heading = 12'(h);
                end
                else
                    it.heading = 12'($urandom);
                if (mv_phase == PH_FWD)
                begin
                    if ($urandom_range(9) == 0)
                        p_odo -= $urandom_range(50);
                    else
                        p_odo += $urandom_range(cfg_now.bypass_mm / 3 + 20);
                    it.odometer_mm = p_odo;
                end
            end
            send_item(it);
        end
    endtask

    // ---------------------------------------------------------------- result check

    task automatic check_result();
        res_t want;
        if (expected_moves.size() == 0)
        begin
            $error("unexpected result: phase %0d direction %0d", phase, direction);
            mismatches++;
        end
        else
        begin
            want = expected_moves.pop_front();
            if (phase !== want.phase)
            begin
                $error("phase: expected %0d, got %0d", want.phase, phase);
                mismatches++;
            end
            if (direction !== want.direction)
            begin
                $error("direction: expected %0d, got %0d", want.direction, direction);
                mismatches++;
            end
            if (left_speed !== want.left_speed)
            begin
                $error("left_speed: expected %0d, got %0d", $signed(want.left_speed), left_speed);
                mismatches++;
            end
            if (right_speed !== want.right_speed)
            begin
                $error("right_speed: expected %0d, got %0d",
                       $signed(want.right_speed), right_speed);
                mismatches++;
            end
            if (start_ok !== want.start_ok)
            begin
                $error("start_ok: expected %0d, got %0d", want.start_ok, start_ok);
                mismatches++;
            end
            phase_hits[want.phase]++;
            results_checked++;
        end
    endtask

    // Take results and stall the output as the current mix asks
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Extremes, refused starts, the unused command, wrapped time and heading,
    // exact distance across the odometer extremes, timeout and restart
    task automatic test_directed();
        logic [31:0] t0;
        logic [31:0] t1;
        t0 = 32'hFFFF_FF00;
        t1 = 32'd1000;
        send_cmd(CMD_UPDATE, t0,        DIR_NONE,  12'd0,    32'd0,        16'd0);
        send_cmd(CMD_UNUSED, t0,        DIR_LEFT,  12'd100,  32'd5,        16'd100);
        send_cmd(CMD_START,  t0,        DIR_NONE,  12'd0,    32'd0,        16'hFFFF);
        send_cmd(CMD_START,  t0,        DIR_BAD,   12'd4095, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_RESET,  t0,        DIR_BAD,   12'd4095, 32'd0,        16'd0);
        // left start past 3599, time wraps through zero while settling
        send_cmd(CMD_START,  t0,        DIR_LEFT,  12'd4095, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 499,  DIR_NONE,  12'd0,    32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 500,  DIR_NONE,  12'd0,    32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 600,  DIR_NONE,  12'd0,    32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 700,  DIR_NONE,  12'd0,    32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 800,  DIR_NONE,  12'd3000, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 900,  DIR_NONE,  12'd1445, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 1199, DIR_NONE,  12'd1345, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 1200, DIR_NONE,  12'd1395, 32'h7FFF_FFFF, 16'd251);
        send_cmd(CMD_UPDATE, t0 + 1300, DIR_NONE,  12'd1395, 32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t0 + 1400, DIR_NONE,  12'd1395, 32'h8000_0000, 16'd250);
        // right start, bypass distance spans the whole odometer, then turn timeout
        send_cmd(CMD_START,  t1,        DIR_RIGHT, 12'd0,    32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 500,  DIR_NONE,  12'd0,    32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 600,  DIR_NONE,  12'd0,    32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 700,  DIR_NONE,  12'd2700, 32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 1000, DIR_NONE,  12'd2651, 32'h8000_0000, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 1100, DIR_NONE,  12'd2651, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 6100, DIR_NONE,  12'd2000, 32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UPDATE, t1 + 6200, DIR_NONE,  12'd0,    32'h7FFF_FFFF, 16'hFFFF);
        // restart while a manoeuvre is running
        send_cmd(CMD_START,  t1 + 7000, DIR_RIGHT, 12'd1800, 32'd0,        16'hFFFF);
        send_cmd(CMD_START,  t1 + 7100, DIR_LEFT,  12'd100,  32'd10,       16'hFFFF);
        drain_results();
    endtask

    // Random manoeuvres under each idling mix
    task automatic test_idling_mix();
        int tx_mix[4] = '{0, 56, 0, 14};
        int rx_mix[4] = '{0, 0, 56, 14};
        for (int m = 0; m < 4; m++)
        begin
            tx_idle_pct  = tx_mix[m];
            rx_stall_pct = rx_mix[m];
            random_items(450);
        end
        drain_results();
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 300;
        random_items(60);
        drain_results();
    endtask

    // Sweep the registers through extremes and random values, back to reset values
    task automatic test_register_sweep();
        cfg_t mix;
        mix = '{16'($urandom_range(2000)), 16'($urandom_range(3000)), 15'($urandom),
                15'($urandom), 12'($urandom_range(3599))};
        tx_idle_pct  = 14;
        rx_stall_pct = 14;
        apply_settings('{16'd0, 16'd0, 15'd0, 15'd0, 12'd0});
        random_items(40);
        apply_settings('{16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 12'd3599});
        random_items(40);
        apply_settings(mix);
        random_items(40);
        apply_settings('{16'd1000, 16'd50, 15'd16384, 15'd1, 12'd4095});
        random_items(40);
        apply_settings(CFG_RESET);
        random_items(40);
        drain_results();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= CMD_UPDATE;
        now_ms      <= '0;
        dir_req     <= DIR_NONE;
        heading     <= '0;
        odometer_mm <= '0;
        front_mm    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 0;
        reset_manoeuvre();
        p_now = $urandom;
        p_odo = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_idling_mix();
        test_backpressure();
        test_register_sweep();
        drain_results();

        $display("Checked %0d results from %0d requests; %0d register writes, four idling mixes",
                 results_checked, requests_sent, reg_writes);
        $display("Results by phase idle..failed: %0d %0d %0d %0d %0d %0d %0d %0d",
                 phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3],
                 phase_hits[4], phase_hits[5], phase_hits[6], phase_hits[7]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[obstacle_bypass_sequencer.f]
hw/rtl/obs_pkg.sv
hw/rtl/obs_cfg.sv
hw/rtl/obs_core.sv
hw/rtl/obstacle_bypass_sequencer.sv
test/obstacle_bypass_sequencer_tb.sv
